[hw/rtl/sonar_point_average_filter_unit_assert.svh]
// Assertion macros for the sonar point average filter.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SONAR_POINT_AVERAGE_FILTER_UNIT_ASSERT_SVH
`define SONAR_POINT_AVERAGE_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SOPAF_CHECK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sopaf check failed");
`define SOPAF_CHECK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sopaf check failed");
`else
`define SOPAF_CHECK_IMPL(label, clk, rst_n, ante, cons)
`define SOPAF_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/sopaf_pkg.sv]
// Package for the sonar point average filter: widths, register codes,
// word and status structs, back-end state type. No dependencies.
`timescale 1ns / 1ps
package sopaf_pkg;
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CH_W       = 4;
  localparam int PT_W       = 32;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = 8;
  localparam int DIST_W     = 31;
  localparam int DIFF_W     = PT_W + 1;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER_AVERAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT     = 2'd2;

  localparam logic [CNT_W-1:0]  POINTS_RST = 8'd8;
  localparam logic [CNT_W-1:0]  IGNORE_RST = 8'd5;
  localparam logic [DIST_W-1:0] DIST_RST   = 31'd65536;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  typedef struct packed {
    logic [CNT_W-1:0]  points_per_average;
    logic [CNT_W-1:0]  ignore_limit;
    logic [DIST_W-1:0] distance_limit;
  } cfg_t;

  typedef struct packed {
    logic                   in_range;
    logic [CH_W-1:0]        channel;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
  } work_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0]        point_count;
    logic [CNT_W-1:0]        ignored_count;
  } chan_rec_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] num_x;
    logic signed [SUM_W-1:0] num_y;
    logic [CNT_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [PT_W-1:0] quo_x;
    logic signed [PT_W-1:0] quo_y;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic in_div;
    logic div_done;
  } back_status_t;

  typedef enum logic [3:0] {
    BK_POP, BK_READ, BK_LOAD, BK_DECIDE, BK_DIV, BK_DIFF, BK_SQ_X, BK_SQ_Y,
    BK_SQ_L, BK_CMP, BK_ACC, BK_REJ, BK_WRITE, BK_OUT
  } back_state_t;

  typedef enum logic {
    MODE_NEAR, MODE_EMIT
  } div_mode_t;
endpackage

[hw/rtl/sopaf_if.sv]
// Channel interfaces: input word, result word, config write.
// Depends on sopaf_pkg.
`timescale 1ns / 1ps
interface sopaf_in_if import sopaf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CH_W-1:0]        channel;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  modport source (output valid, channel, point_x, point_y, input ready);
  modport sink (input valid, channel, point_x, point_y, output ready);
endinterface

interface sopaf_out_if import sopaf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   emit;
  logic signed [PT_W-1:0] mean_x;
  logic signed [PT_W-1:0] mean_y;
  modport source (output valid, emit, mean_x, mean_y, input ready);
  modport sink (input valid, emit, mean_x, mean_y, output ready);
endinterface

interface sopaf_cfg_if import sopaf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sopaf_front.sv]
// Front end: input register stage, tags each word with its channel range check.
// Depends on sopaf_pkg and sopaf_if.
`timescale 1ns / 1ps
module sopaf_front import sopaf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  sopaf_in_if.sink in_ch,
  output work_t    push_data,
  output logic     push_valid,
  input  logic     push_ready
);
  logic  full_r, full_nxt;
  work_t word_r, word_nxt;
  logic  take;

  assign in_ch.ready = !full_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = full_r;
  assign push_data   = word_r;

  always_comb begin
    full_nxt = full_r;
    word_nxt = word_r;
    if (full_r && push_ready) full_nxt = 1'b0;
    if (take) begin
      full_nxt = 1'b1;
      word_nxt.in_range = {{(32-CH_W){1'b0}}, in_ch.channel} < 32'(NUM_CHANNELS);
      word_nxt.channel  = in_ch.channel;
      word_nxt.point_x  = in_ch.point_x;
      word_nxt.point_y  = in_ch.point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else        full_r <= full_nxt;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end
endmodule

[hw/rtl/sopaf_fifo.sv]
// Two-entry queue between front and back end.
// Depends on sopaf_pkg.
`timescale 1ns / 1ps
module sopaf_fifo import sopaf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  work_t        push_data,
  input  logic         push_valid,
  output logic         push_ready,
  output work_t        pop_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output fifo_status_t status
);
  work_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  push, pop;

  assign push_ready   = count_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid    = count_r != '0;
  assign pop_data     = slot_r[rd_ptr_r];
  assign push         = push_valid && push_ready;
  assign pop          = pop_valid && pop_ready;
  assign status.full  = !push_ready;
  assign status.empty = !pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end
endmodule

[hw/rtl/sopaf_div.sv]
// Radix-2 restoring divider, x and y lanes side by side, one quotient bit
// per cycle. Signed 40-bit sum by nonzero 8-bit count. Depends on sopaf_pkg.
`timescale 1ns / 1ps
module sopaf_div import sopaf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]     qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CNT_W-1:0]     rx_r, rx_nxt, ry_r, ry_nxt, den_r, den_nxt;
  logic                 neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [CNT_W:0]       st_x, st_y;
  logic [SUM_W-1:0]     sq_x, sq_y;

  function automatic logic [CNT_W:0] div_step(logic [CNT_W-1:0] rem, logic nb,
                                              logic [CNT_W-1:0] den);
    logic [CNT_W:0] trial;
    trial = {rem, nb};
    if (trial >= {1'b0, den}) return {1'b1, CNT_W'(trial - {1'b0, den})};
    return {1'b0, trial[CNT_W-1:0]};
  endfunction

  function automatic logic [SUM_W-1:0] num_mag(logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  assign st_x      = div_step(rx_r, qx_r[SUM_W-1], den_r);
  assign st_y      = div_step(ry_r, qy_r[SUM_W-1], den_r);
  assign sq_x      = neg_x_r ? (~qx_r + 1'b1) : qx_r;
  assign sq_y      = neg_y_r ? (~qy_r + 1'b1) : qy_r;
  assign rsp.done  = done_r;
  assign rsp.quo_x = sq_x[PT_W-1:0];
  assign rsp.quo_y = sq_y[PT_W-1:0];

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    den_nxt   = den_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      qx_nxt    = num_mag(req.num_x);
      qy_nxt    = num_mag(req.num_y);
      rx_nxt    = '0;
      ry_nxt    = '0;
      den_nxt   = req.den;
      neg_x_nxt = req.num_x[SUM_W-1];
      neg_y_nxt = req.num_y[SUM_W-1];
    end else if (busy_r) begin
      qx_nxt   = {qx_r[SUM_W-2:0], st_x[CNT_W]};
      qy_nxt   = {qy_r[SUM_W-2:0], st_y[CNT_W]};
      rx_nxt   = st_x[CNT_W-1:0];
      ry_nxt   = st_y[CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    den_r   <= den_nxt;
    neg_x_r <= neg_x_nxt;
    neg_y_r <= neg_y_nxt;
  end
endmodule

[hw/rtl/sopaf_back.sv]
// Back end: per-channel state memory, sequencer for flush / accumulate /
// outlier test, shared multiplier, result register. Depends on sopaf_pkg, sopaf_if.
`timescale 1ns / 1ps
module sopaf_back import sopaf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  work_t        pop_data,
  input  logic         pop_valid,
  output logic         pop_ready,
  output div_req_t     div_req,
  input  div_rsp_t     div_rsp,
  sopaf_out_if.source  out_ch,
  output back_status_t status
);
  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  back_state_t state_r, state_nxt;
  div_mode_t   mode_r, mode_nxt;
  work_t       item_r, item_nxt;
  chan_rec_t   rec_r, rec_nxt;
  chan_rec_t   chan_mem [NUM_CHANNELS];
  chan_rec_t   rd_data_r;
  logic        rd_vld_r;
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [CH_W+AW-1:0] ch_ext;
  logic [AW-1:0]      addr;
  logic               mem_we;
  div_req_t           div_req_r, div_req_nxt;

  logic                   res_emit_r, res_emit_nxt;
  logic signed [PT_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                   out_valid_r, out_valid_nxt, out_emit_r, out_emit_nxt;
  logic signed [PT_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]   sqx_r, sqx_nxt, sqy_r, sqy_nxt, sql_r, sql_nxt;
  logic [DIST_W-1:0] mul_a;
  logic [SQ_W-1:0]   mul_p;

  logic [CNT_W-1:0]        need, cnt_acc;
  logic signed [SUM_W-1:0] sum_x_acc, sum_y_acc;
  logic forced_flush, direct_acc, acc_full, far, near;

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [PT_W-1:0] a,
                                                 logic signed [PT_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign ch_ext  = {{AW{1'b0}}, item_r.channel};
  assign addr    = ch_ext[AW-1:0];
  assign div_req = div_req_r;

  assign need         = (cfg.points_per_average == '0) ? CNT_W'(1) : cfg.points_per_average;
  assign forced_flush = (cfg.distance_limit != '0) && (rec_r.ignored_count >= cfg.ignore_limit);
  assign direct_acc   = (cfg.distance_limit == '0) || (rec_r.point_count == '0);
  assign sum_x_acc    = rec_r.sum_x + SUM_W'(item_r.point_x);
  assign sum_y_acc    = rec_r.sum_y + SUM_W'(item_r.point_y);
  assign cnt_acc      = rec_r.point_count + 1'b1;
  assign acc_full     = cnt_acc >= need;
  assign far          = (dx_r >= DIFF_W'(cfg.distance_limit)) ||
                        (dy_r >= DIFF_W'(cfg.distance_limit));
  assign near         = ({1'b0, sqx_r} + {1'b0, sqy_r}) < {1'b0, sql_r};

  always_comb begin
    case (state_r)
      BK_SQ_X: mul_a = dx_r[DIST_W-1:0];
      BK_SQ_Y: mul_a = dy_r[DIST_W-1:0];
      default: mul_a = cfg.distance_limit;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.emit     = out_emit_r;
  assign out_ch.mean_x   = out_x_r;
  assign out_ch.mean_y   = out_y_r;
  assign status.in_div   = state_r == BK_DIV;
  assign status.div_done = div_rsp.done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_POP:    if (pop_valid) state_nxt = pop_data.in_range ? BK_READ : BK_OUT;
      BK_READ:   state_nxt = BK_LOAD;
      BK_LOAD:   state_nxt = BK_DECIDE;
      BK_DECIDE: begin
        if (forced_flush) state_nxt = (rec_r.point_count != '0) ? BK_DIV : BK_WRITE;
        else if (direct_acc) state_nxt = BK_ACC;
        else state_nxt = BK_DIV;
      end
      BK_DIV:    if (div_rsp.done) state_nxt = (mode_r == MODE_NEAR) ? BK_DIFF : BK_WRITE;
      BK_DIFF:   state_nxt = BK_SQ_X;
      BK_SQ_X:   state_nxt = far ? BK_REJ : BK_SQ_Y;
      BK_SQ_Y:   state_nxt = BK_SQ_L;
      BK_SQ_L:   state_nxt = BK_CMP;
      BK_CMP:    state_nxt = near ? BK_ACC : BK_REJ;
      BK_ACC:    state_nxt = acc_full ? BK_DIV : BK_WRITE;
      BK_REJ:    state_nxt = BK_WRITE;
      BK_WRITE:  state_nxt = BK_OUT;
      BK_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = BK_POP;
      default:   state_nxt = BK_POP;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    rec_nxt       = rec_r;
    mode_nxt      = mode_r;
    res_emit_nxt  = res_emit_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    sql_nxt       = sql_r;
    div_req_nxt   = div_req_r;
    div_req_nxt.start = 1'b0;
    out_valid_nxt = out_valid_r;
    out_emit_nxt  = out_emit_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    pop_ready     = 1'b0;
    mem_we        = 1'b0;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (state_r)
      BK_POP: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          item_nxt     = pop_data;
          res_emit_nxt = 1'b0;
          res_x_nxt    = '0;
          res_y_nxt    = '0;
        end
      end
      BK_LOAD: rec_nxt = rd_vld_r ? rd_data_r : '0;
      BK_DECIDE: begin
        if (forced_flush) begin
          rec_nxt      = '0;
          res_emit_nxt = 1'b1;
          if (rec_r.point_count != '0) begin
            div_req_nxt = '{start: 1'b1, num_x: rec_r.sum_x, num_y: rec_r.sum_y,
                            den: rec_r.point_count};
            mode_nxt    = MODE_EMIT;
          end
        end else if (!direct_acc) begin
          div_req_nxt = '{start: 1'b1, num_x: rec_r.sum_x, num_y: rec_r.sum_y,
                          den: rec_r.point_count};
          mode_nxt    = MODE_NEAR;
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          if (mode_r == MODE_NEAR) begin
            dx_nxt = abs_diff(item_r.point_x, div_rsp.quo_x);
            dy_nxt = abs_diff(item_r.point_y, div_rsp.quo_y);
          end else begin
            res_x_nxt = div_rsp.quo_x;
            res_y_nxt = div_rsp.quo_y;
          end
        end
      end
      BK_SQ_X: sqx_nxt = mul_p;
      BK_SQ_Y: sqy_nxt = mul_p;
      BK_SQ_L: sql_nxt = mul_p;
      BK_ACC: begin
        rec_nxt.sum_x       = sum_x_acc;
        rec_nxt.sum_y       = sum_y_acc;
        rec_nxt.point_count = cnt_acc;
        if (acc_full) begin
          div_req_nxt = '{start: 1'b1, num_x: sum_x_acc, num_y: sum_y_acc, den: cnt_acc};
          mode_nxt            = MODE_EMIT;
          res_emit_nxt        = 1'b1;
          rec_nxt.sum_x       = '0;
          rec_nxt.sum_y       = '0;
          rec_nxt.point_count = '0;
        end
      end
      BK_REJ: begin
        if (rec_r.ignored_count != CNT_MAX)
          rec_nxt.ignored_count = rec_r.ignored_count + 1'b1;
      end
      BK_WRITE: mem_we = 1'b1;
      BK_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_emit_nxt  = res_emit_r;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_POP;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      div_req_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) vld_r[addr] <= 1'b1;
      div_req_r   <= div_req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) chan_mem[addr] <= rec_r;
    rd_data_r <= chan_mem[addr];
    rd_vld_r  <= vld_r[addr];
  end

  always_ff @(posedge clk) begin
    item_r          <= item_nxt;
    rec_r           <= rec_nxt;
    mode_r          <= mode_nxt;
    res_emit_r      <= res_emit_nxt;
    res_x_r         <= res_x_nxt;
    res_y_r         <= res_y_nxt;
    dx_r            <= dx_nxt;
    dy_r            <= dy_nxt;
    sqx_r           <= sqx_nxt;
    sqy_r           <= sqy_nxt;
    sql_r           <= sql_nxt;
    out_emit_r      <= out_emit_nxt;
    out_x_r         <= out_x_nxt;
    out_y_r         <= out_y_nxt;
  end
endmodule

[hw/rtl/sonar_point_average_filter_unit.sv]
// A word with an out-of-range channel goes straight to the output; otherwise
// the word may use the shared radix-2 divider (at most two means per word)
// and the squared-distance test.
// The back end holds one word at a time; the front register and 2-entry
// queue buffer 3.
// Reset (sync, active low): control cleared, channel valid bits cleared so all
// channel state reads zero at once, config back to 8 / 5 / 1.0.
`timescale 1ns / 1ps
`include "sonar_point_average_filter_unit_assert.svh"
module sonar_point_average_filter_unit import sopaf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sopaf_in_if.sink    in_ch,
  sopaf_out_if.source out_ch,
  sopaf_cfg_if.sink   cfg_ch
);
  cfg_t         cfg_r, cfg_nxt;
  work_t        push_data, pop_data;
  logic         push_valid, push_ready, pop_valid, pop_ready;
  div_req_t     div_req;
  div_rsp_t     div_rsp;
  fifo_status_t fifo_st;
  back_status_t back_st;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_POINTS_PER_AVERAGE: cfg_nxt.points_per_average = cfg_ch.data[CNT_W-1:0];
        CFG_IGNORE_LIMIT:       cfg_nxt.ignore_limit       = cfg_ch.data[CNT_W-1:0];
        CFG_DISTANCE_LIMIT:     cfg_nxt.distance_limit     = cfg_ch.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.points_per_average <= POINTS_RST;
      cfg_r.ignore_limit       <= IGNORE_RST;
      cfg_r.distance_limit     <= DIST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sopaf_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  sopaf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .status     (fifo_st)
  );

  sopaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sopaf_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_ch    (out_ch),
    .status    (back_st)
  );

  `SOPAF_CHECK_IMPL(a_div_done_in_div, clk, rst_n, back_st.div_done, back_st.in_div)
  `SOPAF_CHECK_IMPL(a_quiet_mean_zero, clk, rst_n, out_ch.valid && !out_ch.emit, out_ch.mean_x == 0 && out_ch.mean_y == 0)
  `SOPAF_CHECK_NEXT(a_full_holds, clk, rst_n, fifo_st.full && !(pop_valid && pop_ready), fifo_st.full)
endmodule
